>>> rtl/sams_pkg.sv
// ----------------------------------------------------------------------------
// sams_pkg: shared types and constants of the servo angle map and sweep block
// Command, status and register index codes, and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sams_pkg;

  localparam int unsigned AngleW = 13;
  localparam int unsigned PulseW = 12;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 13;

  // divider operands: |pulse delta| times |angle delta|, over an angle span
  localparam int unsigned NumW = PulseW + AngleW;
  localparam int unsigned DenW = AngleW;

  typedef enum logic [CmdW-1:0] {
    CMD_TARGET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_CLAMP_MAX = 2'd2,
    ST_CLAMP_MIN = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_ANGLE    = 3'd0,
    REG_CENTER_ANGLE = 3'd1,
    REG_MAX_ANGLE    = 3'd2,
    REG_MIN_PULSE    = 3'd3,
    REG_CENTER_PULSE = 3'd4,
    REG_MAX_PULSE    = 3'd5,
    REG_RANGE_LOW    = 3'd6,
    REG_RANGE_HIGH   = 3'd7
  } cfg_idx_e;

  localparam logic signed [AngleW-1:0] RstMinAngle    = 13'sd0;
  localparam logic signed [AngleW-1:0] RstCenterAngle = 13'sd900;
  localparam logic signed [AngleW-1:0] RstMaxAngle    = 13'sd1800;
  localparam logic [PulseW-1:0] RstMinPulse    = 12'd2300;
  localparam logic [PulseW-1:0] RstCenterPulse = 12'd1450;
  localparam logic [PulseW-1:0] RstMaxPulse    = 12'd600;
  localparam logic [PulseW-1:0] RstRangeLow    = 12'd500;
  localparam logic [PulseW-1:0] RstRangeHigh   = 12'd2500;

  typedef struct packed {
    logic [NumW-1:0] quotient;
    logic [DenW-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

>>> rtl/sams_div.sv
// ----------------------------------------------------------------------------
// sams_div: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses once the result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sams_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sams_pkg::NumW-1:0]  dividend_i,
  input  wire logic [sams_pkg::DenW-1:0]  divisor_i,
  output logic                            done_o,
  output sams_pkg::div_res_t              res_o
);

  localparam int unsigned CntW = $clog2(sams_pkg::NumW);
  localparam logic [CntW-1:0] CntLast = CntW'(sams_pkg::NumW - 1);

  logic                         busy_q;
  logic                         done_q;
  logic [CntW-1:0]              cnt_q;
  logic [sams_pkg::NumW-1:0]    quo_q;
  logic [sams_pkg::DenW-1:0]    rem_q;
  logic [sams_pkg::DenW-1:0]    den_q;
  logic [sams_pkg::DenW:0]      shifted;
  logic [sams_pkg::DenW:0]      trial;
  logic                         fits;

  assign shifted = {rem_q, quo_q[sams_pkg::NumW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[sams_pkg::NumW-2:0], fits};
      rem_q <= fits ? trial[sams_pkg::DenW-1:0] : shifted[sams_pkg::DenW-1:0];
    end
  end

  assign done_o          = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/servo_angle_map_sweep.sv
// ----------------------------------------------------------------------------
// servo_angle_map_sweep: servo angle to pulse mapper with 1 us/tick sweep
// Maps target angles through a three point piecewise linear curve, steps the
// driven pulse toward the target on each tick, and sweeps to center on stop.
//
//   Input words (cmd_i, target_angle_i) arrive on in_valid_i/in_ready_o and
//   each one yields exactly one output word (pulse_us_o, status_o,
//   busy_res_o) on out_valid_o/out_ready_i. The user must write registers
//   through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no word is in flight;
//   the block does not enforce this. Target and stop words that interpolate
//   pass setup, multiply, divider load, the divider steps (one per quotient
//   bit), done and finish before output valid rises; words that clamp or hit
//   the center point pass setup and finish, tick and no-op words finish only.
//   The shared restoring divider works one quotient bit a cycle. One word is
//   in work at a time; in_ready_o is high only when idle.
//   A finished word waits in the output register; while the receiver stalls
//   the block still accepts and works the next word, and holds its result
//   until the output register frees.
//   Reset loads the default curve, centers position and target at 1450 us
//   and leaves the output on.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_angle_map_sweep (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sams_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [sams_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [sams_pkg::CmdW-1:0]         cmd_i,
  input  wire logic signed [sams_pkg::AngleW-1:0] target_angle_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [sams_pkg::PulseW-1:0]            pulse_us_o,
  output logic [sams_pkg::StatW-1:0]             status_o,
  output logic                                   busy_res_o
);

  localparam int unsigned AW = sams_pkg::AngleW;
  localparam int unsigned PW = sams_pkg::PulseW;
  localparam int unsigned SW = PW + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [AW-1:0] min_angle_q, center_angle_q, max_angle_q;
  logic [PW-1:0] min_pulse_q, center_pulse_q, max_pulse_q, range_low_q, range_high_q;

  // block state
  logic [PW-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic          stopping_q, stopping_d, off_q, off_d;

  // work registers
  sams_pkg::cmd_e        cmd_q;
  logic signed [AW-1:0]  ang_q;
  logic [PW-1:0]         base_q;
  sams_pkg::status_e     map_st_q;
  logic                  interp_q;
  logic                  neg_q;
  logic [PW-1:0]         pmag_q;
  logic [AW-1:0]         amag_q;
  logic [AW-1:0]         den_q;
  logic [sams_pkg::NumW-1:0] prod_q;

  // output register
  logic                  out_valid_q;
  logic [PW-1:0]         out_pulse_q;
  sams_pkg::status_e     out_status_q;
  logic                  out_busy_q;

  logic                  in_fire;
  logic                  out_free;
  logic                  fin_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign fin_fire = (state_q == S_FIN) && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q    <= sams_pkg::RstMinAngle;
      center_angle_q <= sams_pkg::RstCenterAngle;
      max_angle_q    <= sams_pkg::RstMaxAngle;
      min_pulse_q    <= sams_pkg::RstMinPulse;
      center_pulse_q <= sams_pkg::RstCenterPulse;
      max_pulse_q    <= sams_pkg::RstMaxPulse;
      range_low_q    <= sams_pkg::RstRangeLow;
      range_high_q   <= sams_pkg::RstRangeHigh;
    end else if (cfg_we_i) begin
      unique case (sams_pkg::cfg_idx_e'(cfg_idx_i))
        sams_pkg::REG_MIN_ANGLE:    min_angle_q    <= $signed(cfg_wdata_i[AW-1:0]);
        sams_pkg::REG_CENTER_ANGLE: center_angle_q <= $signed(cfg_wdata_i[AW-1:0]);
        sams_pkg::REG_MAX_ANGLE:    max_angle_q    <= $signed(cfg_wdata_i[AW-1:0]);
        sams_pkg::REG_MIN_PULSE:    min_pulse_q    <= cfg_wdata_i[PW-1:0];
        sams_pkg::REG_CENTER_PULSE: center_pulse_q <= cfg_wdata_i[PW-1:0];
        sams_pkg::REG_MAX_PULSE:    max_pulse_q    <= cfg_wdata_i[PW-1:0];
        sams_pkg::REG_RANGE_LOW:    range_low_q    <= cfg_wdata_i[PW-1:0];
        sams_pkg::REG_RANGE_HIGH:   range_high_q   <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // segment selection
  logic gt_max, lt_min, lt_ctr, gt_ctr, lower;
  logic signed [AW:0] ang_x, lo_x, hi_x, ad_w, den_w;
  logic signed [PW:0] pd_w, pd_neg;

  assign gt_max = ang_q > max_angle_q;
  assign lt_min = ang_q < min_angle_q;
  assign lt_ctr = ang_q < center_angle_q;
  assign gt_ctr = ang_q > center_angle_q;
  assign lower  = lt_ctr;

  always_comb begin
    ang_x = {ang_q[AW-1], ang_q};
    lo_x  = lower ? {min_angle_q[AW-1], min_angle_q} : {center_angle_q[AW-1], center_angle_q};
    hi_x  = lower ? {center_angle_q[AW-1], center_angle_q} : {max_angle_q[AW-1], max_angle_q};
    ad_w  = ang_x - lo_x;
    den_w = hi_x - lo_x;
    pd_w  = lower ? ($signed({1'b0, center_pulse_q}) - $signed({1'b0, min_pulse_q}))
                  : ($signed({1'b0, max_pulse_q}) - $signed({1'b0, center_pulse_q}));
    pd_neg = -pd_w;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= sams_pkg::cmd_e'(cmd_i);
      ang_q <= (sams_pkg::cmd_e'(cmd_i) == sams_pkg::CMD_TARGET) ? target_angle_i
                                                                 : center_angle_q;
    end
    if (state_q == S_SETUP) begin
      interp_q <= 1'b0;
      map_st_q <= sams_pkg::ST_OK;
      if (gt_max) begin
        base_q   <= max_pulse_q;
        map_st_q <= sams_pkg::ST_CLAMP_MAX;
      end else if (lt_min) begin
        base_q   <= min_pulse_q;
        map_st_q <= sams_pkg::ST_CLAMP_MIN;
      end else if (lt_ctr || gt_ctr) begin
        base_q   <= lower ? min_pulse_q : center_pulse_q;
        interp_q <= 1'b1;
      end else begin
        base_q <= center_pulse_q;
      end
      neg_q  <= pd_w[PW];
      pmag_q <= pd_w[PW] ? pd_neg[PW-1:0] : pd_w[PW-1:0];
      amag_q <= ad_w[AW-1:0];
      den_q  <= den_w[AW-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= pmag_q * amag_q;
    end
  end

  // shared divider
  logic               div_done;
  sams_pkg::div_res_t div_res;

  sams_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (sams_pkg::cmd_e'(cmd_i) == sams_pkg::CMD_TARGET ||
              sams_pkg::cmd_e'(cmd_i) == sams_pkg::CMD_STOP) begin
            state_d = S_SETUP;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SETUP: begin
        state_d = (!gt_max && !lt_min && (lt_ctr || gt_ctr)) ? S_MUL : S_FIN;
      end
      S_MUL:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result and state update
  logic [SW-1:0]     q_ext, q_adj, qs, pmap;
  logic              in_rng;
  logic [PW-1:0]     drive;
  sams_pkg::status_e st_out;

  always_comb begin
    q_ext  = {2'b00, div_res.quotient[PW-1:0]};
    q_adj  = q_ext + SW'(div_res.remainder != '0);
    qs     = !interp_q ? '0 : (neg_q ? -q_adj : q_ext);
    pmap   = {2'b00, base_q} + qs;
    in_rng = ($signed(pmap) >= $signed({2'b00, range_low_q})) &&
             ($signed(pmap) <= $signed({2'b00, range_high_q}));

    pos_d      = pos_q;
    tgt_d      = tgt_q;
    stopping_d = stopping_q;
    off_d      = off_q;
    st_out     = sams_pkg::ST_OK;
    drive      = pos_q;

    case (cmd_q) inside
      sams_pkg::CMD_TARGET, sams_pkg::CMD_STOP: begin
        if (in_rng) begin
          tgt_d  = pmap[PW-1:0];
          st_out = map_st_q;
          if (cmd_q == sams_pkg::CMD_TARGET) begin
            stopping_d = 1'b0;
            off_d      = 1'b0;
          end
        end else begin
          st_out = sams_pkg::ST_REJECT;
        end
        if (cmd_q == sams_pkg::CMD_STOP) begin
          stopping_d = 1'b1;
        end
        drive = off_d ? '0 : pos_q;
      end
      sams_pkg::CMD_TICK: begin
        if (off_q) begin
          drive = '0;
        end else begin
          drive = pos_q;
          if (pos_q < tgt_q) begin
            pos_d = pos_q + PW'(1);
          end else if (pos_q > tgt_q) begin
            pos_d = pos_q - PW'(1);
          end else if (stopping_q) begin
            off_d = 1'b1;
          end
        end
      end
      default: begin
        drive = off_q ? '0 : pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= sams_pkg::RstCenterPulse;
      tgt_q       <= sams_pkg::RstCenterPulse;
      stopping_q  <= 1'b0;
      off_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        pos_q       <= pos_d;
        tgt_q       <= tgt_d;
        stopping_q  <= stopping_d;
        off_q       <= off_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_pulse_q  <= drive;
      out_status_q <= st_out;
      out_busy_q   <= pos_d != tgt_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pulse_us_o    = out_pulse_q;
  assign status_o      = out_status_q;
  assign busy_res_o    = out_busy_q;

  // checks
  a_off_implies_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q |-> stopping_q)
    else $error("output off without stopping");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_valid_q && !out_ready_i |=> (state_q == S_FIN))
    else $error("result left finish while output blocked");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SETUP) || (state_q == S_FIN))
    else $error("accepted word did not start work");

endmodule

`default_nettype wire
